FILE: rtl/edge_interval_capture_fifo_top_assert.svh
// ----------------------------------------------------------------------------
// edge interval capture fifo assertion macros
// shared property wrappers, compiled out when NO_ASSERTIONS is set
// ----------------------------------------------------------------------------
`ifndef EDGE_INTERVAL_CAPTURE_FIFO_TOP_ASSERT_SVH
`define EDGE_INTERVAL_CAPTURE_FIFO_TOP_ASSERT_SVH

`ifndef NO_ASSERTIONS

// expression must hold on every clock edge out of reset
`define EICF_ASSERT_ALWAYS(label, expr) \
   label: assert property (@(posedge clock) disable iff (reset) (expr)) \
      else $error("eicf: invariant violated");

// consequent must hold in the cycle after the antecedent
`define EICF_ASSERT_NEXT(label, ante, cons) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error("eicf: next-cycle check violated");

`else

`define EICF_ASSERT_ALWAYS(label, expr)
`define EICF_ASSERT_NEXT(label, ante, cons)

`endif

`endif

FILE: rtl/eicf_pkg.sv
// ----------------------------------------------------------------------------
// eicf_pkg
// types and constants shared by the edge interval capture fifo
// ----------------------------------------------------------------------------
package eicf_pkg;

   localparam int DEPTH_DEFAULT     = 256;
   localparam int MAX_BURST_DEFAULT = 64;

   localparam int ACTION_W    = 2;
   localparam int TIME_W      = 63;
   localparam int COUNT_W     = 7;
   localparam int DURATION_W  = 32;

   // request action codes
   localparam logic [ACTION_W-1:0] ACT_EDGE  = 2'd0;
   localparam logic [ACTION_W-1:0] ACT_READ  = 2'd1;
   localparam logic [ACTION_W-1:0] ACT_CLEAR = 2'd2;

   typedef struct packed {
      logic [ACTION_W-1:0] action;
      logic [TIME_W-1:0]   now_us;
      logic [COUNT_W-1:0]  pop_limit;
   } req_type;

   typedef struct packed {
      logic [DURATION_W-1:0] duration;
      logic                  has_data;
      logic                  last;
   } rsp_type;

   // controller to datapath
   typedef struct packed {
      logic edge_evt;
      logic clear;
      logic pop;
   } cmd_type;

   // datapath to controller
   typedef struct packed {
      logic empty;
      logic next_empty;
   } stat_type;

   // controller to output assembly
   typedef struct packed {
      logic valid;
      logic has_data;
      logic last;
   } rsp_flags_type;

endpackage

FILE: rtl/eicf_ram.sv
// ----------------------------------------------------------------------------
// eicf_ram
// single write port, single read port ram with registered read data
// ----------------------------------------------------------------------------
module eicf_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 256
) (
   input  logic                                    clock,
   input  logic                                    wr_en,
   input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] wr_addr,
   input  logic [WIDTH-1:0]                        wr_data,
   input  logic                                    rd_en,
   input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] rd_addr,
   output logic [WIDTH-1:0]                        rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

FILE: rtl/eicf_dp.sv
// ----------------------------------------------------------------------------
// eicf_dp
// ring pointers, last edge time, interval subtraction and the interval ram
// ----------------------------------------------------------------------------
module eicf_dp #(
   parameter int DEPTH = eicf_pkg::DEPTH_DEFAULT
) (
   input  logic                                clock,
   input  logic                                reset,
   input  eicf_pkg::cmd_type                   cmd,
   input  logic [eicf_pkg::TIME_W-1:0]         now_us,
   output eicf_pkg::stat_type                  stat,
   output logic [eicf_pkg::DURATION_W-1:0]     rd_duration
);
   import eicf_pkg::*;

   localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam logic [AW-1:0] LAST_SLOT = AW'(DEPTH - 1);

   logic [AW-1:0]         wp_ff, wp_in;
   logic [AW-1:0]         rp_ff, rp_in;
   logic [TIME_W-1:0]     prev_ff, prev_in;
   logic [AW-1:0]         wp_next;
   logic [AW-1:0]         rp_next;
   logic [DURATION_W-1:0] interval;
   logic                  push;

   assign wp_next  = (wp_ff == LAST_SLOT) ? '0 : wp_ff + AW'(1);
   assign rp_next  = (rp_ff == LAST_SLOT) ? '0 : rp_ff + AW'(1);
   assign interval = now_us[DURATION_W-1:0] - prev_ff[DURATION_W-1:0];

   // a full ring keeps one slot free and drops the new interval
   assign push = cmd.edge_evt && (prev_ff != '0) && (wp_next != rp_ff);

   always_comb begin
      wp_in   = wp_ff;
      rp_in   = rp_ff;
      prev_in = prev_ff;
      if (cmd.clear) begin
         wp_in   = '0;
         rp_in   = '0;
         prev_in = '0;
      end else begin
         if (cmd.edge_evt) begin
            prev_in = now_us;
         end
         if (push) begin
            wp_in = wp_next;
         end
         if (cmd.pop) begin
            rp_in = rp_next;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wp_ff   <= '0;
         rp_ff   <= '0;
         prev_ff <= '0;
      end else begin
         wp_ff   <= wp_in;
         rp_ff   <= rp_in;
         prev_ff <= prev_in;
      end
   end

   assign stat.empty      = (rp_ff == wp_ff);
   assign stat.next_empty = (rp_next == wp_ff);

   eicf_ram #(
      .WIDTH (DURATION_W),
      .DEPTH (DEPTH)
   ) u_ram (
      .clock   (clock),
      .wr_en   (push),
      .wr_addr (wp_ff),
      .wr_data (interval),
      .rd_en   (cmd.pop),
      .rd_addr (rp_ff),
      .rd_data (rd_duration)
   );

endmodule

FILE: rtl/eicf_ctrl.sv
// ----------------------------------------------------------------------------
// eicf_ctrl
// request decode and read burst sequencer
// ----------------------------------------------------------------------------
module eicf_ctrl #(
   parameter int MAX_BURST = eicf_pkg::MAX_BURST_DEFAULT
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          start,
   input  logic [eicf_pkg::ACTION_W-1:0] action,
   input  logic [eicf_pkg::COUNT_W-1:0]  pop_limit,
   input  eicf_pkg::stat_type            stat,
   output logic                          busy,
   output eicf_pkg::cmd_type             cmd,
   output eicf_pkg::rsp_flags_type       rsp_flags
);
   import eicf_pkg::*;

   localparam int LW = $clog2(MAX_BURST + 1);
   localparam int CW = (LW > COUNT_W) ? LW : COUNT_W;

   typedef enum logic {
      ST_IDLE,
      ST_BURST
   } state_type;

   state_type     state_ff, state_in;
   logic [LW-1:0] remain_ff, remain_in;
   logic          vld_ff, vld_in;
   logic          has_ff, has_in;
   logic          last_ff, last_in;

   logic          accept;
   logic [CW-1:0] req_ext;
   logic [CW-1:0] limit;

   assign accept  = start && (state_ff == ST_IDLE);
   assign req_ext = CW'(pop_limit);
   assign limit   = (req_ext > CW'(MAX_BURST)) ? CW'(MAX_BURST) : req_ext;

   always_comb begin
      state_in     = state_ff;
      remain_in    = remain_ff;
      vld_in       = 1'b0;
      has_in       = 1'b0;
      last_in      = 1'b0;
      cmd.edge_evt = 1'b0;
      cmd.clear    = 1'b0;
      cmd.pop      = 1'b0;
      unique case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               unique case (action)
                  ACT_EDGE: begin
                     cmd.edge_evt = 1'b1;
                  end
                  ACT_CLEAR: begin
                     cmd.clear = 1'b1;
                  end
                  ACT_READ: begin
                     if (stat.empty || (limit == '0)) begin
                        // nothing to pop: single empty word
                        vld_in  = 1'b1;
                        last_in = 1'b1;
                     end else begin
                        cmd.pop = 1'b1;
                        vld_in  = 1'b1;
                        has_in  = 1'b1;
                        last_in = (limit == CW'(1)) || stat.next_empty;
                        if (!last_in) begin
                           state_in  = ST_BURST;
                           remain_in = LW'(limit - CW'(1));
                        end
                     end
                  end
                  default: begin
                  end
               endcase
            end
         end
         ST_BURST: begin
            cmd.pop   = 1'b1;
            vld_in    = 1'b1;
            has_in    = 1'b1;
            last_in   = (remain_ff == LW'(1)) || stat.next_empty;
            remain_in = remain_ff - LW'(1);
            if (last_in) begin
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff  <= ST_IDLE;
         remain_ff <= '0;
         vld_ff    <= 1'b0;
         has_ff    <= 1'b0;
         last_ff   <= 1'b0;
      end else begin
         state_ff  <= state_in;
         remain_ff <= remain_in;
         vld_ff    <= vld_in;
         has_ff    <= has_in;
         last_ff   <= last_in;
      end
   end

   assign busy               = (state_ff == ST_BURST);
   assign rsp_flags.valid    = vld_ff;
   assign rsp_flags.has_data = has_ff;
   assign rsp_flags.last     = last_ff;

endmodule

FILE: rtl/edge_interval_capture_fifo_top.sv
// ----------------------------------------------------------------------------
// edge_interval_capture_fifo_top
// edge interval capture into a ring buffer with burst readout
// ----------------------------------------------------------------------------
//  channel   ports                          handshake
//  request   start, busy, req_item          taken when start and not busy
//  response  rsp_valid, rsp_item            one cycle per word, no back-pressure
//
//  edge and clear give no word and leave busy low
//  a read of n entries keeps busy high while its later entries pop; words follow one per
//  cycle starting the cycle after the read is taken, paced by the ram read port
//  an empty read or a zero count gives one word with has_data low, in the cycle after
//  reset clears pointers and last edge time; ram contents need no clearing
// ----------------------------------------------------------------------------
`include "edge_interval_capture_fifo_top_assert.svh"

module edge_interval_capture_fifo_top #(
   parameter int DEPTH     = eicf_pkg::DEPTH_DEFAULT,
   parameter int MAX_BURST = eicf_pkg::MAX_BURST_DEFAULT
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              start,
   output logic              busy,
   input  eicf_pkg::req_type req_item,
   output logic              rsp_valid,
   output eicf_pkg::rsp_type rsp_item
);
   import eicf_pkg::*;

   cmd_type               cmd;
   stat_type              stat;
   rsp_flags_type         rsp_flags;
   logic [DURATION_W-1:0] rd_duration;

   eicf_ctrl #(
      .MAX_BURST (MAX_BURST)
   ) u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .start     (start),
      .action    (req_item.action),
      .pop_limit (req_item.pop_limit),
      .stat      (stat),
      .busy      (busy),
      .cmd       (cmd),
      .rsp_flags (rsp_flags)
   );

   eicf_dp #(
      .DEPTH (DEPTH)
   ) u_dp (
      .clock       (clock),
      .reset       (reset),
      .cmd         (cmd),
      .now_us      (req_item.now_us),
      .stat        (stat),
      .rd_duration (rd_duration)
   );

   assign rsp_valid         = rsp_flags.valid;
   assign rsp_item.duration = rsp_flags.has_data ? rd_duration : '0;
   assign rsp_item.has_data = rsp_flags.has_data;
   assign rsp_item.last     = rsp_flags.last;

   `EICF_ASSERT_NEXT(a_read_answers, start && !busy && (req_item.action == ACT_READ), rsp_valid)
   `EICF_ASSERT_NEXT(a_burst_streams, busy, rsp_valid && rsp_item.has_data)
   `EICF_ASSERT_ALWAYS(a_empty_word_is_last, !rsp_valid || rsp_item.has_data || rsp_item.last)
   `EICF_ASSERT_ALWAYS(a_no_pop_when_empty, !cmd.pop || !stat.empty)

endmodule

FILE: tb/edge_interval_capture_fifo_checker.sv
// ----------------------------------------------------------------------------
// edge_interval_capture_fifo_checker
// watches the request and response channels, keeps its own copy of the ring
// and the last edge time, and compares every response word against it
// ----------------------------------------------------------------------------
module edge_interval_capture_fifo_checker (
   input  logic              clock,
   input  logic              reset,
   input  logic              start,
   input  logic              busy,
   input  eicf_pkg::req_type req_item,
   input  logic              rsp_valid,
   input  eicf_pkg::rsp_type rsp_item,
   output int unsigned       fail_count,
   output int unsigned       words_pending
);
   timeunit 1ns;
   timeprecision 1ps;
   import eicf_pkg::*;

   localparam int unsigned RING  = DEPTH_DEFAULT;
   localparam int unsigned BURST = MAX_BURST_DEFAULT;

   logic [DURATION_W-1:0] interval_ram [RING];
   int unsigned           wr_idx;
   int unsigned           rd_idx;
   logic [TIME_W-1:0]     last_edge_us;
   rsp_type               expected_words [$];

   initial begin
      fail_count    = 0;
      words_pending = 0;
   end

   task automatic report_mismatch(input string msg);
      $display("%0t ns  mismatch: %s", $time, msg);
      fail_count++;
   endtask

   task automatic capture_edge(input logic [TIME_W-1:0] now);
      logic [TIME_W-1:0] gap;
      int unsigned       nxt;
      gap = now - last_edge_us;
      nxt = (wr_idx + 1) % RING;
      // one slot stays empty, so a full ring drops the interval
      if (last_edge_us != '0 && nxt != rd_idx) begin
         interval_ram[wr_idx] = gap[DURATION_W-1:0];
         wr_idx = nxt;
      end
      last_edge_us = now;
   endtask

   task automatic drain_burst(input logic [COUNT_W-1:0] count);
      int unsigned want;
      int unsigned n;
      int unsigned nxt;
      rsp_type     w;
      want = (count > BURST) ? BURST : count;
      n = 0;
      while (rd_idx != wr_idx && n < want) begin
         nxt = (rd_idx + 1) % RING;
         w.duration = interval_ram[rd_idx];
         w.has_data = 1'b1;
         w.last     = (n + 1 == want) || (nxt == wr_idx);
         expected_words.push_back(w);
         rd_idx = nxt;
         n++;
      end
      if (n == 0) begin
         w = '0;
         w.last = 1'b1;
         expected_words.push_back(w);
      end
   endtask

   always @(posedge clock) begin
      rsp_type want;
      if (reset) begin
         expected_words.delete();
         wr_idx       = 0;
         rd_idx       = 0;
         last_edge_us = '0;
      end else begin
         if (rsp_valid) begin
            if (expected_words.size() == 0) begin
               report_mismatch($sformatf("word %h with none expected", rsp_item));
            end else begin
               want = expected_words.pop_front();
               if (rsp_item.duration !== want.duration)
                  report_mismatch($sformatf("duration %h, predicted %h",
                                            rsp_item.duration, want.duration));
               if (rsp_item.has_data !== want.has_data)
                  report_mismatch($sformatf("has_data %b, predicted %b",
                                            rsp_item.has_data, want.has_data));
               if (rsp_item.last !== want.last)
                  report_mismatch($sformatf("last %b, predicted %b",
                                            rsp_item.last, want.last));
            end
         end
         if (start && !busy) begin
            case (req_item.action)
               ACT_EDGE:  capture_edge(req_item.now_us);
               ACT_READ:  drain_burst(req_item.pop_limit);
               ACT_CLEAR: begin
                  wr_idx       = 0;
                  rd_idx       = 0;
                  last_edge_us = '0;
               end
               default: ;  // unused code leaves everything alone
            endcase
         end
      end
      words_pending = expected_words.size();
   end

endmodule

FILE: tb/edge_interval_capture_fifo_top_tb.sv
// ----------------------------------------------------------------------------
// edge_interval_capture_fifo_top_tb
// drives edge, read, clear and unused commands with random sender gaps; a
// checker beside the block predicts every response word and counts mismatches
// ----------------------------------------------------------------------------
module edge_interval_capture_fifo_top_tb;
   timeunit 1ns;
   timeprecision 1ps;
   import eicf_pkg::*;

   localparam logic [ACTION_W-1:0] ACT_UNUSED   = 2'd3;
   localparam int unsigned         CYCLE_LIMIT  = 300000;
   localparam int unsigned         RANDOM_ITEMS = 24;

   logic              clock = 1'b0;
   logic              reset = 1'b1;
   logic              start = 1'b0;
   req_type           req_item = '0;
   logic              busy;
   logic              rsp_valid;
   rsp_type           rsp_item;
   int unsigned       fail_count;
   int unsigned       words_pending;
   int unsigned       cycle_count = 0;
   int unsigned       idle_pct = 0;
   logic [TIME_W-1:0] stamp_us = '0;

   always #10 clock = ~clock;

   edge_interval_capture_fifo_top dut (
      .clock     (clock),
      .reset     (reset),
      .start     (start),
      .busy      (busy),
      .req_item  (req_item),
      .rsp_valid (rsp_valid),
      .rsp_item  (rsp_item)
   );

   edge_interval_capture_fifo_checker checker_inst (
      .clock         (clock),
      .reset         (reset),
      .start         (start),
      .busy          (busy),
      .req_item      (req_item),
      .rsp_valid     (rsp_valid),
      .rsp_item      (rsp_item),
      .fail_count    (fail_count),
      .words_pending (words_pending)
   );

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count == CYCLE_LIMIT) begin
         $display("Regression FAIL");
         $finish;
      end
   end

   // start stays high from one word to the next unless a gap is drawn
   task automatic issue_word(input logic [ACTION_W-1:0] act,
                             input logic [TIME_W-1:0]   ts,
                             input logic [COUNT_W-1:0]  count);
      start    <= 1'b1;
      req_item <= '{action: act, now_us: ts, pop_limit: count};
      do @(posedge clock); while (busy);
      if ($urandom_range(99) < idle_pct) begin
         start <= 1'b0;
         repeat ($urandom_range(1, 6)) @(posedge clock);
      end
   endtask

   function automatic logic [TIME_W-1:0] random_stamp();
      return TIME_W'({$urandom(), $urandom()});
   endfunction

   function automatic logic [COUNT_W-1:0] random_count();
      int unsigned pick;
      pick = $urandom_range(99);
      if (pick < 10) return '0;
      if (pick < 70) return COUNT_W'($urandom_range(1, 8));
      if (pick < 88) return COUNT_W'($urandom_range(9, 64));
      return COUNT_W'($urandom_range(65, 127));
   endfunction

   task automatic advance_stamp();
      case ($urandom_range(19))
         0:       stamp_us = random_stamp();
         1:       stamp_us = stamp_us - TIME_W'($urandom_range(1, 5000));  // time going backwards
         2:       stamp_us = stamp_us + TIME_W'({$urandom_range(255), $urandom()});
         3:       stamp_us = '0;
         4:       ;  // same stamp again, zero interval
         default: stamp_us = stamp_us + TIME_W'($urandom_range(1, 100000));
      endcase
   endtask

   initial begin
      int unsigned sent;
      int unsigned run;
      int unsigned pick;
      repeat (8) @(posedge clock);
      reset <= 1'b0;

      // directed corners
      issue_word(ACT_READ,   '0,      '0);       // empty ring, zero count
      issue_word(ACT_READ,   '0,      7'd64);    // empty ring
      issue_word(ACT_EDGE,   '0,      '0);
      issue_word(ACT_EDGE,   '0,      '0);
      issue_word(ACT_EDGE,   63'd1000, '0);      // no previous edge held
      issue_word(ACT_EDGE,   63'd1250, '0);
      issue_word(ACT_EDGE,   '1,      '1);       // huge gap, truncated
      issue_word(ACT_EDGE,   63'd5,   '0);       // backwards, wraps
      issue_word(ACT_EDGE,   '0,      '0);       // wraps, then forgets the edge
      issue_word(ACT_EDGE,   63'd77,  '0);
      issue_word(ACT_UNUSED, '1,      '1);
      issue_word(ACT_READ,   '1,      '0);       // zero count with data waiting
      issue_word(ACT_READ,   '0,      7'd2);
      issue_word(ACT_READ,   '0,      '1);       // clamped, fewer left
      issue_word(ACT_READ,   '0,      7'd1);
      issue_word(ACT_EDGE,   63'd100, '0);
      issue_word(ACT_CLEAR,  '0,      '0);
      issue_word(ACT_READ,   '0,      7'd3);
      issue_word(ACT_EDGE,   63'd40,  '0);
      issue_word(ACT_EDGE,   63'd40,  '0);       // zero interval
      issue_word(ACT_EDGE,   63'h2AAA_AAAA_AAAA_AAAA, '0);
      issue_word(ACT_READ,   '0,      7'd65);

      // fill the ring past full, then drain it in clamped bursts
      idle_pct = 66;
      issue_word(ACT_CLEAR, random_stamp(), random_count());
      stamp_us = 63'd1;
      repeat (258) begin
         stamp_us = stamp_us + TIME_W'($urandom_range(1, 3000));
         issue_word(ACT_EDGE, stamp_us, random_count());
      end
      issue_word(ACT_READ, random_stamp(), 7'd127);
      issue_word(ACT_READ, random_stamp(), 7'd65);
      issue_word(ACT_READ, random_stamp(), 7'd64);
      issue_word(ACT_READ, random_stamp(), 7'd100);
      issue_word(ACT_READ, random_stamp(), 7'd5);

      for (int ph = 0; ph < 4; ph++) begin
         idle_pct = (ph == 1) ? 66 : (ph == 2) ? 26 : 0;
         sent = 0;
         while (sent < RANDOM_ITEMS / 4) begin
            pick = $urandom_range(99);
            if (pick < 45) begin
               run = $urandom_range(1, 6);
               repeat (run) begin
                  advance_stamp();
                  issue_word(ACT_EDGE, stamp_us, random_count());
               end
               sent += run;
            end else if (pick < 82) begin
               issue_word(ACT_READ, random_stamp(), random_count());
               sent++;
            end else if (pick < 87) begin
               issue_word(ACT_CLEAR, random_stamp(), random_count());
               sent++;
            end else if (pick < 92) begin
               issue_word(ACT_UNUSED, random_stamp(), random_count());
            end else begin
               issue_word(ACT_EDGE, random_stamp(), random_count());
               sent++;
            end
         end
      end

      start <= 1'b0;
      // let the checker take in the last accepted word first
      @(posedge clock);
      while (words_pending != 0) @(posedge clock);
      repeat (8) @(posedge clock);
      if (fail_count == 0) $display("Regression PASS");
      else $display("Regression FAIL");
      $finish;
   end

endmodule
